### hw/rtl/stww_pkg.sv
`timescale 1ns / 1ps
package stww_pkg;

  localparam int MAX_COLS = 63;
  localparam int DEPTH    = MAX_COLS + 1;
  localparam int AW       = $clog2(DEPTH);
  localparam int FW       = AW + 1;
  localparam logic [FW-1:0] NO_SLOT = {FW{1'b1}};

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  localparam int APB_AW = 3;
  localparam logic REG_LINE_WIDTH = 1'b0;

  localparam int TDATA_W = 72;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MARK,
    ST_FLUSH
  } ctrl_state_e;

  // one buffered cell, bytes in the lowest bits
  typedef struct packed {
    logic        bold;
    logic [31:0] color;
    logic [2:0]  count;
    logic [31:0] bytes;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef struct packed {
    cell_t glyph;
    logic  final_req;
    logic  carries_nothing;
  } in_item_t;

  typedef struct packed {
    logic  last_result;
    logic  line_end;
    logic  blank_line;
    logic  run_start;
    cell_t glyph;
  } out_item_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    cell_t         wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage

### hw/rtl/styled_text_word_wrap.sv
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      code point, count, color, bold; tlast final
// m_axis    out  m_axis_tvalid/tready      emitted cell; tuser run/blank; tlast line end
// apb       in   psel/penable/pwrite       register 0 wrap_columns at byte address 0
//
// An item is taken only while the controller is idle. A segment of cells then takes
// one line buffer read, then one cell per cycle unless the output stalls; a marker
// segment is one result. A final item adds a flush step plus its flush segment.
// Reset clears the line state; the line buffer needs no clearing pass.
// Output stalls hold the result register and freeze the cell readout.
`timescale 1ns / 1ps
module styled_text_word_wrap
  import stww_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [31:0] code_point_bytes, [34:32] byte_count, [66:35] color, [67] bold
  input  logic [TDATA_W-1:0] s_axis_tdata,
  // [0] carries_nothing
  input  logic               s_axis_tuser,
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [31:0] out_bytes, [34:32] out_count, [66:35] out_color, [67] out_bold,
  // [68] last_result
  output logic [TDATA_W-1:0] m_axis_tdata,
  // [0] run_start, [1] blank_line
  output logic [1:0]         m_axis_tuser,
  output logic               m_axis_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [5:0] line_width;
  in_item_t   s_item;
  mem_req_t   mem_req;
  cell_t      mem_rdata;
  logic       out_free;
  logic       out_load;
  out_item_t  out_item;
  out_item_t  m_item;

  assign s_item.glyph           = cell_t'(s_axis_tdata[CELL_W-1:0]);
  assign s_item.final_req       = s_axis_tlast;
  assign s_item.carries_nothing = s_axis_tuser;

  stww_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .line_width_o(line_width)
  );

  stww_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .re_i   (mem_req.re),
    .raddr_i(mem_req.raddr),
    .rdata_o(mem_rdata)
  );

  stww_line_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .line_width_i(line_width),
    .s_valid_i   (s_axis_tvalid),
    .s_item_i    (s_item),
    .s_ready_o   (s_axis_tready),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_item_o  (out_item)
  );

  stww_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .item_i (out_item),
    .free_o (out_free),
    .ready_i(m_axis_tready),
    .valid_o(m_axis_tvalid),
    .item_o (m_item)
  );

  assign m_axis_tdata = {{(TDATA_W - CELL_W - 1){1'b0}}, m_item.last_result, m_item.glyph};
  assign m_axis_tuser = {m_item.blank_line, m_item.run_start};
  assign m_axis_tlast = m_item.line_end;

endmodule

### hw/rtl/stww_ram.sv
`timescale 1ns / 1ps
module stww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hw/rtl/stww_cfg.sv
`timescale 1ns / 1ps
module stww_cfg
  import stww_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [5:0]        line_width_o
);

  logic [5:0] wrap_q, wrap_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    wrap_d = wrap_q;
    if (wr_en && paddr[2] == REG_LINE_WIDTH) begin
      wrap_d = pwdata[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= '0;
    end else begin
      wrap_q <= wrap_d;
    end
  end

  assign prdata       = (paddr[2] == REG_LINE_WIDTH) ? {26'b0, wrap_q} : 32'b0;
  assign line_width_o = wrap_q;

endmodule

### hw/rtl/stww_line_ctrl.sv
`timescale 1ns / 1ps
module stww_line_ctrl
  import stww_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [5:0] line_width_i,
  input  logic       s_valid_i,
  input  in_item_t   s_item_i,
  output logic       s_ready_o,
  output mem_req_t   mem_req_o,
  input  cell_t      mem_rdata_i,
  input  logic       out_free_i,
  output logic       out_load_o,
  output out_item_t  out_item_o
);

  ctrl_state_e state_q, state_d;

  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] space_q, space_d;
  logic [32:0]   prev_style_q, prev_style_d;
  logic          open_q, open_d;
  logic [FW-1:0] rem_q, rem_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic          pass_q, pass_d;
  logic          flush_q, flush_d;

  logic          acc;
  logic [2:0]    cnt_n;
  logic [31:0]   bytes_n;
  logic          is_space;
  logic [FW-1:0] cols_fw;
  logic          seg_go;
  logic          seg_pass;
  logic [FW-1:0] seg_n;
  logic [AW-1:0] head_n;
  logic [FW-1:0] fill_n;
  logic [FW-1:0] space_n;
  logic          seg_end;
  logic [32:0]   rd_style;

  function automatic logic [31:0] byte_mask(input logic [2:0] cnt);
    logic [31:0] m;
    case (cnt)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  assign s_ready_o = (state_q == ST_IDLE);
  assign acc       = s_valid_i & s_ready_o;
  assign cols_fw   = {1'b0, line_width_i};
  assign seg_end   = (rem_q == FW'(1));
  assign rd_style  = {mem_rdata_i.bold, mem_rdata_i.color};

  // normalize the incoming code point
  always_comb begin
    if (s_item_i.glyph.count == 3'd0) begin
      cnt_n = 3'd1;
    end else if (s_item_i.glyph.count > 3'd4) begin
      cnt_n = 3'd4;
    end else begin
      cnt_n = s_item_i.glyph.count;
    end
    bytes_n  = s_item_i.glyph.bytes & byte_mask(cnt_n);
    is_space = (cnt_n == 3'd1) && (bytes_n[7:0] == SPACE_BYTE);
  end

  // break decision for the accepted item
  always_comb begin
    seg_go   = 1'b0;
    seg_pass = 1'b0;
    seg_n    = '0;
    head_n   = head_q;
    fill_n   = fill_q;
    space_n  = space_q;
    if (!s_item_i.carries_nothing) begin
      if (line_width_i == 6'd0) begin
        // pass through all but the newest cell
        seg_go   = (fill_q != '0);
        seg_pass = 1'b1;
        seg_n    = fill_q;
        head_n   = head_q + fill_q[AW-1:0];
        fill_n   = FW'(1);
        space_n  = is_space ? '0 : NO_SLOT;
      end else if (fill_q >= cols_fw) begin
        seg_go  = 1'b1;
        space_n = NO_SLOT;
        if (!is_space && space_q < fill_q) begin
          // soft break: drop the space, carry the tail
          seg_n  = space_q;
          head_n = head_q + space_q[AW-1:0] + AW'(1);
          fill_n = fill_q - space_q;
        end else if (is_space) begin
          seg_n  = fill_q;
          fill_n = '0;
        end else begin
          seg_n  = fill_q;
          head_n = head_q + fill_q[AW-1:0];
          fill_n = FW'(1);
        end
      end else begin
        fill_n  = fill_q + FW'(1);
        space_n = is_space ? fill_q : space_q;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (seg_go) begin
            state_d = (seg_n == '0) ? ST_MARK : ST_READ;
          end else if (s_item_i.final_req) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free_i && seg_end) begin
          state_d = flush_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_MARK: begin
        if (out_free_i) begin
          state_d = flush_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        state_d = (fill_q == '0) ? ST_MARK : ST_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d       = head_q;
    fill_d       = fill_q;
    space_d      = space_q;
    prev_style_d = prev_style_q;
    open_d       = open_q;
    rem_d        = rem_q;
    rd_ptr_d     = rd_ptr_q;
    pass_d       = pass_q;
    flush_d      = flush_q;

    mem_req_o       = '0;
    mem_req_o.waddr = head_q + fill_q[AW-1:0];
    mem_req_o.wdata = '{bold: s_item_i.glyph.bold, color: s_item_i.glyph.color,
                        count: cnt_n, bytes: bytes_n};
    mem_req_o.raddr = rd_ptr_q;

    out_load_o = 1'b0;
    out_item_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          mem_req_o.we = ~s_item_i.carries_nothing;
          head_d   = head_n;
          fill_d   = fill_n;
          space_d  = space_n;
          rem_d    = seg_n;
          rd_ptr_d = head_q;
          pass_d   = seg_pass;
          flush_d  = s_item_i.final_req;
        end
      end
      ST_READ: begin
        mem_req_o.re = 1'b1;
        rd_ptr_d     = rd_ptr_q + AW'(1);
      end
      ST_LOAD: begin
        out_load_o             = 1'b1;
        out_item_o.glyph       = mem_rdata_i;
        out_item_o.run_start   = !open_q || (rd_style != prev_style_q);
        out_item_o.line_end    = seg_end && !pass_q;
        out_item_o.last_result = seg_end && !flush_q;
        if (out_free_i) begin
          prev_style_d = rd_style;
          open_d       = pass_q || !seg_end;
          rem_d        = rem_q - FW'(1);
          if (!seg_end) begin
            // fetch the next cell while this one leaves
            mem_req_o.re = 1'b1;
            rd_ptr_d     = rd_ptr_q + AW'(1);
          end
        end
      end
      ST_MARK: begin
        out_load_o             = 1'b1;
        out_item_o.blank_line  = !open_q;
        out_item_o.line_end    = 1'b1;
        out_item_o.last_result = !flush_q;
        if (out_free_i) begin
          open_d = 1'b0;
        end
      end
      ST_FLUSH: begin
        rd_ptr_d = head_q;
        rem_d    = fill_q;
        fill_d   = '0;
        space_d  = NO_SLOT;
        pass_d   = 1'b0;
        flush_d  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      fill_q       <= '0;
      space_q      <= NO_SLOT;
      prev_style_q <= '0;
      open_q       <= 1'b0;
      rem_q        <= '0;
      rd_ptr_q     <= '0;
      pass_q       <= 1'b0;
      flush_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      space_q      <= space_d;
      prev_style_q <= prev_style_d;
      open_q       <= open_d;
      rem_q        <= rem_d;
      rd_ptr_q     <= rd_ptr_d;
      pass_q       <= pass_d;
      flush_q      <= flush_d;
    end
  end

endmodule

### hw/rtl/stww_out_reg.sv
`timescale 1ns / 1ps
module stww_out_reg
  import stww_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t item_i,
  output logic      free_o,
  input  logic      ready_i,
  output logic      valid_o,
  output out_item_t item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q, item_d;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (free_o) begin
      valid_d = load_i;
      if (load_i) begin
        item_d = item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hw/rtl/stww_checker.sv
`timescale 1ns / 1ps
module stww_checker
  import stww_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]         m_axis_tuser,
  input logic               m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // more results of the same item pending: no new item taken
  a_no_accept_mid_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[CELL_W] |-> !s_axis_tready)
    else $error("input taken while an item still has results");

  // a blank-line marker carries no code point and ends its line
  a_blank_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tdata[34:32] == 3'd0 && m_axis_tlast && !m_axis_tuser[0])
    else $error("malformed blank-line marker");

  // emitted cells hold one to four bytes
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[34:32] != 3'd0 |-> m_axis_tdata[34:32] <= 3'd4)
    else $error("cell byte count out of range");

endmodule

bind styled_text_word_wrap stww_checker u_stww_checker (.*);
